>>> rtl/fsk_tss_pkg.sv
// fsk_tss_pkg: shared types and constants for the fsk tone symbol sequencer
// holds queue sizing, register map, action codes, symbol codes and reset values
// no dependencies; used by fsk_tss_queue and fsk_tone_symbol_sequencer
package fsk_tss_pkg;

  // symbol queue sizing
  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // symbol codes as held in the queue
  localparam int SYM_W = 2;
  localparam logic [SYM_W-1:0] SYM_A = 2'd0;
  localparam logic [SYM_W-1:0] SYM_B = 2'd1;
  localparam logic [SYM_W-1:0] SYM_C = 2'd2;
  localparam logic [SYM_W-1:0] SYM_D = 2'd3;

  // field widths
  localparam int CFG_W   = 16;
  localparam int TICK_W  = 16;
  localparam int WORD_W  = 32;
  localparam int TOTAL_W = 32;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_BITS  = 8 + 1;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = WORD_W + QCNT_W + 1 + TOTAL_W + TOTAL_W;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  // register interface
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_TONE_MS      = 3'd0,
    REG_WARMUP_LEN   = 3'd1,
    REG_SILENCE_MS   = 3'd2,
    REG_CARRIER_FREQ = 3'd3,
    REG_BIT0_FREQ    = 3'd4,
    REG_BIT1_FREQ    = 3'd5,
    REG_EOF_FREQ     = 3'd6
  } reg_idx_t;

  // register reset values
  localparam logic [CFG_W-1:0] RST_TONE_MS      = 16'd144;
  localparam logic [CFG_W-1:0] RST_WARMUP_LEN   = 16'd300;
  localparam logic [CFG_W-1:0] RST_SILENCE_MS   = 16'd400;
  localparam logic [CFG_W-1:0] RST_CARRIER_FREQ = 16'd2014;
  localparam logic [CFG_W-1:0] RST_BIT0_FREQ    = 16'd3571;
  localparam logic [CFG_W-1:0] RST_BIT1_FREQ    = 16'd4577;
  localparam logic [CFG_W-1:0] RST_EOF_FREQ     = 16'd2930;

  // input item kinds
  localparam logic OP_CHAR = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // result actions
  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_START = 2'd1,
    ACT_STOP  = 2'd2
  } action_t;

  // queue control and status between top level and queue
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [SYM_W-1:0] sym;
  } q_ctrl_t;

  typedef struct packed {
    logic [QCNT_W-1:0] level;
    logic [QCNT_W-1:0] level_next;
    logic [SYM_W-1:0]  tail_sym;
  } q_stat_t;

endpackage

>>> rtl/fsk_tss_queue.sv
// fsk_tss_queue: symbol queue with overwrite of the oldest entry when full
// register array with head, tail and fill count; tail entry read combinationally
// depends on fsk_tss_pkg
module fsk_tss_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  fsk_tss_pkg::q_ctrl_t  ctrl,
  output fsk_tss_pkg::q_stat_t  stat
);

  logic [fsk_tss_pkg::SYM_W-1:0]  entries [fsk_tss_pkg::QUEUE_DEPTH];
  logic [fsk_tss_pkg::QIDX_W-1:0] head;
  logic [fsk_tss_pkg::QIDX_W-1:0] tail;
  logic [fsk_tss_pkg::QCNT_W-1:0] count;
  logic [fsk_tss_pkg::QCNT_W-1:0] level_next;
  logic [fsk_tss_pkg::QIDX_W-1:0] head_inc;
  logic [fsk_tss_pkg::QIDX_W-1:0] tail_inc;
  logic                           full;

  localparam logic [fsk_tss_pkg::QIDX_W-1:0] LAST_IDX =
    fsk_tss_pkg::QIDX_W'(fsk_tss_pkg::QUEUE_DEPTH - 1);
  localparam logic [fsk_tss_pkg::QCNT_W-1:0] FULL_CNT =
    fsk_tss_pkg::QCNT_W'(fsk_tss_pkg::QUEUE_DEPTH);

  // wrapping index increments
  assign head_inc = (head == LAST_IDX) ? '0 : head + 1'b1;
  assign tail_inc = (tail == LAST_IDX) ? '0 : tail + 1'b1;
  assign full     = (count == FULL_CNT);

  // fill count after this cycle's push or pop
  always_comb begin
    level_next = count;
    if (ctrl.push && !full) begin
      level_next = count + 1'b1;
    end else if (ctrl.pop) begin
      level_next = count - 1'b1;
    end
  end

  // status seen by the top level
  assign stat = {count, level_next, entries[tail]};

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= level_next;
      if (ctrl.push) begin
        head <= head_inc;
        if (full) begin
          tail <= tail_inc;
        end
      end else if (ctrl.pop) begin
        tail <= tail_inc;
      end
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entries[head] <= ctrl.sym;
    end
  end

endmodule

>>> rtl/fsk_tone_symbol_sequencer.sv
// fsk_tone_symbol_sequencer: top level of the fsk tone symbol sequencer
// queues protocol characters and plays them as timed start, stop and silence
// depends on fsk_tss_pkg and fsk_tss_queue
//
// usage
//   s_* channel: one item per character or millisecond tick; s_tuser is the
//   item kind (0 character, 1 tick), s_tdata carries the character and the
//   channel busy flag. characters a-d / A-D are queued, others ignored.
//   m_* channel: exactly one result item per input item; m_tuser is the
//   action (none, start, stop), m_tdata carries the tone word, queue level,
//   player busy flag and the received and emitted totals.
//   the apb port sets the tone, warmup and silence lengths in ticks and the
//   carrier and data tone codes; registers sit at byte address 4*index.
// timing
//   each accepted item is handled whole: state and the result register update at
//   the accepting edge, and the result is shown on the next cycle. with the
//   receiver ready, one item is accepted every cycle.
//   s_tready follows the result register: while a result waits unread,
//   s_tready stays low, and it rises in the cycle the result is taken.
// reset
//   rst (synchronous) empties the queue, puts the player idle, clears the
//   totals and the result valid flag, and loads the default register values.
module fsk_tone_symbol_sequencer (
  input  logic                                  clk,
  input  logic                                  rst,
  // input items
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  input  logic [fsk_tss_pkg::IN_DATA_W-1:0]     s_tdata,  // char_byte[7:0], channel_busy[8]
  input  logic                                  s_tuser,  // op
  // result items
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // tone_word[31:0], queue_level[36:32], player_busy[37],
  // received_count[69:38], emitted_count[101:70]
  output logic [fsk_tss_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [1:0]                            m_tuser,  // action
  // configuration
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [fsk_tss_pkg::PADDR_W-1:0]       paddr,
  input  logic [fsk_tss_pkg::PDATA_W-1:0]       pwdata,
  output logic [fsk_tss_pkg::PDATA_W-1:0]       prdata,
  output logic                                  pready
);

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_TONE    = 2'd1,
    PH_SILENCE = 2'd2
  } phase_t;

  // configuration registers
  logic [fsk_tss_pkg::CFG_W-1:0] tone_ms;
  logic [fsk_tss_pkg::CFG_W-1:0] warm_len;
  logic [fsk_tss_pkg::CFG_W-1:0] silence_ms;
  logic [fsk_tss_pkg::CFG_W-1:0] carrier_freq;
  logic [fsk_tss_pkg::CFG_W-1:0] bit0_freq;
  logic [fsk_tss_pkg::CFG_W-1:0] bit1_freq;
  logic [fsk_tss_pkg::CFG_W-1:0] eof_freq;

  logic                          cfg_wr;
  fsk_tss_pkg::reg_idx_t         cfg_idx;

  // player state
  phase_t                          phase;
  phase_t                          phase_next;
  logic [fsk_tss_pkg::TICK_W-1:0]  elapsed;
  logic [fsk_tss_pkg::TICK_W-1:0]  elapsed_next;
  logic [fsk_tss_pkg::TICK_W-1:0]  elapsed_inc;
  logic                            warmup;
  logic                            warmup_next;
  logic [fsk_tss_pkg::TOTAL_W-1:0] rx_total;
  logic [fsk_tss_pkg::TOTAL_W-1:0] rx_total_next;
  logic [fsk_tss_pkg::TOTAL_W-1:0] emitted_total;
  logic [fsk_tss_pkg::TOTAL_W-1:0] emitted_total_next;

  // input item fields
  logic                           accept;
  logic                           in_op;
  logic [7:0]                     in_char;
  logic                           in_busy;
  logic                           sym_ok;
  logic [fsk_tss_pkg::SYM_W-1:0]  in_sym;

  // step results
  fsk_tss_pkg::action_t           act;
  logic [fsk_tss_pkg::WORD_W-1:0] word;
  logic [fsk_tss_pkg::CFG_W-1:0]  data_freq;
  logic [fsk_tss_pkg::CFG_W-1:0]  tone_len;

  fsk_tss_pkg::q_ctrl_t           q_ctrl;
  fsk_tss_pkg::q_stat_t           q_stat;

  // apb register port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = fsk_tss_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_ms      <= fsk_tss_pkg::RST_TONE_MS;
      warm_len     <= fsk_tss_pkg::RST_WARMUP_LEN;
      silence_ms   <= fsk_tss_pkg::RST_SILENCE_MS;
      carrier_freq <= fsk_tss_pkg::RST_CARRIER_FREQ;
      bit0_freq    <= fsk_tss_pkg::RST_BIT0_FREQ;
      bit1_freq    <= fsk_tss_pkg::RST_BIT1_FREQ;
      eof_freq     <= fsk_tss_pkg::RST_EOF_FREQ;
    end else if (cfg_wr) begin
      case (cfg_idx)
        fsk_tss_pkg::REG_TONE_MS:      tone_ms      <= pwdata[fsk_tss_pkg::CFG_W-1:0];
        fsk_tss_pkg::REG_WARMUP_LEN:   warm_len     <= pwdata[fsk_tss_pkg::CFG_W-1:0];
        fsk_tss_pkg::REG_SILENCE_MS:   silence_ms   <= pwdata[fsk_tss_pkg::CFG_W-1:0];
        fsk_tss_pkg::REG_CARRIER_FREQ: carrier_freq <= pwdata[fsk_tss_pkg::CFG_W-1:0];
        fsk_tss_pkg::REG_BIT0_FREQ:    bit0_freq    <= pwdata[fsk_tss_pkg::CFG_W-1:0];
        fsk_tss_pkg::REG_BIT1_FREQ:    bit1_freq    <= pwdata[fsk_tss_pkg::CFG_W-1:0];
        fsk_tss_pkg::REG_EOF_FREQ:     eof_freq     <= pwdata[fsk_tss_pkg::CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (cfg_idx)
      fsk_tss_pkg::REG_TONE_MS:      prdata = fsk_tss_pkg::PDATA_W'(tone_ms);
      fsk_tss_pkg::REG_WARMUP_LEN:   prdata = fsk_tss_pkg::PDATA_W'(warm_len);
      fsk_tss_pkg::REG_SILENCE_MS:   prdata = fsk_tss_pkg::PDATA_W'(silence_ms);
      fsk_tss_pkg::REG_CARRIER_FREQ: prdata = fsk_tss_pkg::PDATA_W'(carrier_freq);
      fsk_tss_pkg::REG_BIT0_FREQ:    prdata = fsk_tss_pkg::PDATA_W'(bit0_freq);
      fsk_tss_pkg::REG_BIT1_FREQ:    prdata = fsk_tss_pkg::PDATA_W'(bit1_freq);
      fsk_tss_pkg::REG_EOF_FREQ:     prdata = fsk_tss_pkg::PDATA_W'(eof_freq);
      default:                       prdata = '0;
    endcase
  end

  // input handshake and field unpacking
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign in_op    = s_tuser;
  assign in_char  = s_tdata[7:0];
  assign in_busy  = s_tdata[8];

  // protocol character decode: a-d and A-D map to symbols A..D
  assign sym_ok = ((in_char >= 8'h61) && (in_char <= 8'h64)) ||
                  ((in_char >= 8'h41) && (in_char <= 8'h44));
  assign in_sym = in_char[1:0] - 2'd1;

  // saturating tick count
  assign elapsed_inc = (elapsed != '1) ? elapsed + 1'b1 : elapsed;
  assign tone_len    = warmup ? warm_len : tone_ms;

  // data tone for the symbol at the queue tail
  always_comb begin
    case (q_stat.tail_sym)
      fsk_tss_pkg::SYM_A: data_freq = bit0_freq;
      fsk_tss_pkg::SYM_B: data_freq = bit1_freq;
      default:            data_freq = eof_freq;
    endcase
  end

  // one step of the player and queue for the offered item
  always_comb begin
    phase_next         = phase;
    elapsed_next       = elapsed;
    warmup_next        = warmup;
    rx_total_next      = rx_total;
    emitted_total_next = emitted_total;
    act                = fsk_tss_pkg::ACT_NONE;
    word               = '0;
    q_ctrl             = '0;
    q_ctrl.sym         = in_sym;
    if (in_op == fsk_tss_pkg::OP_CHAR) begin
      if (sym_ok) begin
        q_ctrl.push   = accept;
        rx_total_next = rx_total + 1'b1;
      end
    end else begin
      case (phase)
        PH_TONE: begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= tone_len) begin
            act          = fsk_tss_pkg::ACT_STOP;
            elapsed_next = '0;
            phase_next   = PH_SILENCE;
          end
        end
        PH_SILENCE: begin
          elapsed_next = elapsed_inc;
          if (elapsed_inc >= silence_ms) begin
            emitted_total_next = emitted_total + 1'b1;
            elapsed_next       = '0;
            phase_next         = PH_IDLE;
          end
        end
        default: begin
          phase_next = PH_IDLE;
          if (!in_busy && (q_stat.level != '0)) begin
            q_ctrl.pop   = accept;
            act          = fsk_tss_pkg::ACT_START;
            word         = {data_freq, carrier_freq};
            warmup_next  = (q_stat.tail_sym == fsk_tss_pkg::SYM_D);
            elapsed_next = '0;
            phase_next   = PH_TONE;
          end
        end
      endcase
    end
  end

  fsk_tss_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (q_ctrl),
    .stat (q_stat)
  );

  // player state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      elapsed       <= '0;
      warmup        <= 1'b0;
      rx_total      <= '0;
      emitted_total <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      elapsed       <= elapsed_next;
      warmup        <= warmup_next;
      rx_total      <= rx_total_next;
      emitted_total <= emitted_total_next;
    end
  end

  // result register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      m_tuser <= act;
      m_tdata <= fsk_tss_pkg::OUT_DATA_W'({emitted_total_next,
                                           rx_total_next,
                                           (phase_next != PH_IDLE),
                                           q_stat.level_next,
                                           word});
    end
  end

  // a shown start result leaves the player in its tone phase
  a_start_in_tone: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == fsk_tss_pkg::ACT_START)) |-> (phase == PH_TONE))
    else $error("start result shown while player not in tone phase");

  // a shown stop result leaves the player in its silence phase
  a_stop_in_silence: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser == fsk_tss_pkg::ACT_STOP)) |-> (phase == PH_SILENCE))
    else $error("stop result shown while player not in silence phase");

  // reported busy flag tracks the player phase after each item
  a_busy_tracks_phase: assert property (@(posedge clk) disable iff (rst)
    accept |=> (m_tdata[fsk_tss_pkg::WORD_W + fsk_tss_pkg::QCNT_W] == (phase != PH_IDLE)))
    else $error("player busy flag does not match phase");

  // an empty queue never starts a tone
  a_no_start_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_op == fsk_tss_pkg::OP_TICK) && (q_stat.level == '0))
      |=> (m_tuser != fsk_tss_pkg::ACT_START))
    else $error("tone started from an empty queue");

endmodule
